>>> sv/png_row_unfilter_top_macros.svh
// Assertion macros shared by the png row unfilter checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef PNG_ROW_UNFILTER_TOP_MACROS_SVH
`define PNG_ROW_UNFILTER_TOP_MACROS_SVH

// Check a property outside reset
`define PRU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define PRU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/pru_pkg.sv
// Shared types, constants and the Paeth predictor for the png row unfilter.
// No dependencies.
`timescale 1ns / 1ps

package pru_pkg;

	localparam int DATA_W = 8;
	localparam int CFG_W  = 13;
	localparam logic [CFG_W-1:0] ROW_LENGTH_RST = CFG_W'(4);

	// Row filter codes; FILT_BAD marks a type byte above four
	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4,
		FILT_BAD   = 3'd5
	} filter_t;

	// Pick left, above or above-left, whichever lies nearest a + b - c
	function automatic logic [DATA_W-1:0] paeth_pick(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] c);
		logic signed [DATA_W+1:0] sa, sb, sc, da, db, dc, pa, pb, pc;
		logic [DATA_W-1:0] pick;
		sa = signed'({2'b00, a});
		sb = signed'({2'b00, b});
		sc = signed'({2'b00, c});
		da = sb - sc;
		db = sa - sc;
		dc = sa + sb - (sc <<< 1);
		pa = (da < 0) ? -da : da;
		pb = (db < 0) ? -db : db;
		pc = (dc < 0) ? -dc : dc;
		if (pa <= pb && pa <= pc) begin
			pick = a;
		end else if (pb <= pc) begin
			pick = b;
		end else begin
			pick = c;
		end
		return pick;
	endfunction

endpackage

>>> sv/png_row_unfilter_top.sv
// PNG scanline unfilter: byte stream in, reconstructed bytes out.
// The first byte of each row is its filter type and yields no output byte; each
// following byte is reconstructed in the cycle it is accepted and appears on the
// output in the next cycle, so the block sustains one byte per clock unless stalled.
// The rate is set by the single read port of the row store, which fetches the byte
// above for the next data byte in the cycle before it arrives (with a bypass when
// that entry is being written). The row store holds MAX_ROW_BYTES bytes, is not
// cleared after reset and needs no clearing pass; a row longer than the one
// before it sees stale above bytes. Write row_length only while the stream is idle.
// Depends on pru_pkg.
`timescale 1ns / 1ps

module png_row_unfilter_top
	import pru_pkg::*;
#(
	parameter int BYTES_PER_PIXEL = 4,
	parameter int MAX_ROW_BYTES   = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	// Row length register write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,
	// Filtered byte stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic              s_tuser,   // [0] image_start
	// Reconstructed byte stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [7:0] pixel_byte
	output logic              m_tlast,   // last_in_row
	output logic              m_tuser    // [0] bad_filter
);

	localparam int IW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int CW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;

	logic [CFG_W-1:0]  row_length_q;
	logic              expect_filter_q;
	logic [IW-1:0]     idx_q;
	filter_t           row_filter_q;
	logic              have_prior_q;
	logic [DATA_W-1:0] left_q [BYTES_PER_PIXEL];
	logic [DATA_W-1:0] upl_q  [BYTES_PER_PIXEL];

	logic [DATA_W-1:0] row_mem [MAX_ROW_BYTES];
	logic [DATA_W-1:0] mem_rd_q;
	logic              byp_q;
	logic [DATA_W-1:0] byp_data_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_bad_q;

	logic              accept, take_filter, wr_en, last;
	logic [CW-1:0]     len_raw, eff_len;
	logic [IW-1:0]     idx_n, rd_addr;
	logic [DATA_W-1:0] a, b, c, pred, result;
	logic [DATA_W:0]   avg_sum;
	filter_t           new_filter;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RST;
		end else if (cfg_valid) begin
			row_length_q <= cfg_data;
		end
	end

	// Accept whenever the output register is free or being emptied
	assign s_tready    = !out_valid_q || m_tready;
	assign accept      = s_tvalid && s_tready;
	assign take_filter = s_tuser || expect_filter_q;
	assign wr_en       = accept && !take_filter;

	// Clamp row length to one .. MAX_ROW_BYTES
	always_comb begin
		len_raw = CW'(row_length_q);
		if (len_raw == '0) begin
			eff_len = CW'(1);
		end else if (len_raw > CW'(MAX_ROW_BYTES)) begin
			eff_len = CW'(MAX_ROW_BYTES);
		end else begin
			eff_len = len_raw;
		end
	end

	assign last = (CW'(idx_q) + CW'(1)) >= eff_len;

	// Neighbours: left, above, above-left
	assign a = left_q[BYTES_PER_PIXEL-1];
	assign c = upl_q[BYTES_PER_PIXEL-1];
	assign b = have_prior_q ? (byp_q ? byp_data_q : mem_rd_q) : '0;

	assign avg_sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		unique case (row_filter_q)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = avg_sum[DATA_W:1];
			FILT_PAETH: pred = paeth_pick(a, b, c);
			default:    pred = '0;
		endcase
	end

	assign result = s_tdata + pred;

	assign new_filter = (s_tdata <= DATA_W'(FILT_PAETH)) ? filter_t'(s_tdata[2:0]) : FILT_BAD;

	// Index of the next data byte, used to prefetch its above byte
	always_comb begin
		idx_n = idx_q;
		if (accept) begin
			if (take_filter || last) begin
				idx_n = '0;
			end else begin
				idx_n = idx_q + IW'(1);
			end
		end
	end
	assign rd_addr = idx_n;

	// Row control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_filter_q <= 1'b1;
			idx_q           <= '0;
			row_filter_q    <= FILT_NONE;
			have_prior_q    <= 1'b0;
		end else if (accept) begin
			idx_q <= idx_n;
			if (take_filter) begin
				expect_filter_q <= 1'b0;
				row_filter_q    <= new_filter;
				if (s_tuser) begin
					have_prior_q <= 1'b0;
				end
			end else if (last) begin
				expect_filter_q <= 1'b1;
				have_prior_q    <= 1'b1;
			end
		end
	end

	// Left and above-left history: clear at a type byte, shift on data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
				left_q[k] <= '0;
				upl_q[k]  <= '0;
			end
		end else if (accept) begin
			if (take_filter) begin
				for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
					left_q[k] <= '0;
					upl_q[k]  <= '0;
				end
			end else begin
				for (int k = BYTES_PER_PIXEL - 1; k > 0; k--) begin
					left_q[k] <= left_q[k-1];
					upl_q[k]  <= upl_q[k-1];
				end
				left_q[0] <= result;
				upl_q[0]  <= b;
			end
		end
	end

	// Row store: write the reconstructed byte, read the next above byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[idx_q] <= result;
		end
		mem_rd_q <= row_mem[rd_addr];
	end

	// Bypass when the prefetch hits the entry written in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= wr_en && (rd_addr == idx_q);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= result;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_byte_q <= result;
			out_last_q <= last;
			out_bad_q  <= (row_filter_q == FILT_BAD);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;

endmodule

>>> sv/pru_checker.sv
// Port-level checks for the png row unfilter, bound to the top level.
// Depends on pru_pkg and png_row_unfilter_top_macros.svh.
`timescale 1ns / 1ps
`include "png_row_unfilter_top_macros.svh"

module pru_checker
	import pru_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              s_tuser,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// Hold a stalled output request
	`PRU_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled output changed")

	// Stop taking input while a result waits
	`PRU_ASSERT(a_no_overrun, m_tvalid && !m_tready |-> !s_tready, "input taken over a waiting result")

	// Drop nothing out for an image start byte
	`PRU_ASSERT(a_start_silent, s_tvalid && s_tready && s_tuser |=> !m_tvalid, "image start byte produced output")

	// Show no output during reset
	`PRU_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !m_tvalid, "output valid in reset")

endmodule

bind png_row_unfilter_top pru_checker u_pru_checker (.*);

>>> tb/tb_png_row_unfilter_top.sv
// Self-checking bench for png_row_unfilter_top: row filter reconstruction on a byte stream.
// Holds its own unfilter predictor and a queue of expected bytes; depends on pru_pkg.
`timescale 1ns / 1ps

module tb_png_row_unfilter_top
	import pru_pkg::*;
();

	localparam int BPP           = 4;
	localparam int ROW_MAX       = 4096;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_BYTES  = 1350;
	localparam int LONG_PART     = 120;
	localparam int CFG_MAX       = (1 << CFG_W) - 1;

	typedef struct packed {
		logic [DATA_W-1:0] pixel;
		logic              last;
		logic              bad;
	} pixel_t;

	typedef struct {
		logic [DATA_W-1:0] data;
		logic              start;
		bit                typed;
		pixel_t            want;
	} stim_row_t;

	logic              clk       = 1'b0;
	logic              arst_n;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data  = ROW_LENGTH_RST;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata   = '0;
	logic              s_tuser   = 1'b0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	// Predictor state: length register, row store and the per-row history
	logic [CFG_W-1:0]  model_len_reg;
	logic [DATA_W-1:0] above_store   [ROW_MAX];
	bit                above_written [ROW_MAX];
	logic [DATA_W-1:0] recent_out    [BPP];
	logic [DATA_W-1:0] recent_above  [BPP];
	int unsigned       row_pos;
	filter_t           row_filt;
	bit                above_valid;

	pixel_t pending_pixels[$];
	int     mismatches = 0;
	int     bytes_sent = 0;
	int     pixels_seen = 0;
	int     cfg_writes = 0;
	bit     send_calm = 1'b0;
	bit     recv_calm = 1'b0;

	// Opening rows at the reset length of four; typed rows are plain pass-through bytes
	stim_row_t opening [0:24] = '{
		// first row of an image, no filter: bytes pass straight through
		'{DATA_W'(FILT_NONE), 1'b1, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0}},
		'{8'h80, 1'b0, 1'b1, '{8'h80, 1'b0, 1'b0}},
		'{8'h7F, 1'b0, 1'b1, '{8'h7F, 1'b1, 1'b0}},
		// top type byte is unknown: bytes pass through flagged
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b1}},
		'{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1}},
		'{8'h01, 1'b0, 1'b1, '{8'h01, 1'b0, 1'b1}},
		'{8'hFE, 1'b0, 1'b1, '{8'hFE, 1'b1, 1'b1}},
		// Up over the flagged row
		'{DATA_W'(FILT_UP), 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h02, 1'b0, 1'b0, '0},
		// Paeth, abandoned after one byte
		'{DATA_W'(FILT_PAETH), 1'b0, 1'b0, '0},
		'{8'h55, 1'b0, 1'b0, '0},
		// new image mid-row: Average with no row above
		'{DATA_W'(FILT_AVG), 1'b1, 1'b0, '0},
		'{8'h10, 1'b0, 1'b0, '0},
		'{8'hF0, 1'b0, 1'b0, '0},
		'{8'hAA, 1'b0, 1'b0, '0},
		'{8'h33, 1'b0, 1'b0, '0},
		// Sub, left open after two bytes for a length change
		'{DATA_W'(FILT_SUB), 1'b0, 1'b0, '0},
		'{8'h9C, 1'b0, 1'b0, '0},
		'{8'h63, 1'b0, 1'b0, '0}
	};

	png_row_unfilter_top #(
		.BYTES_PER_PIXEL(BPP),
		.MAX_ROW_BYTES  (ROW_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// Guard against a hung block
	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Advance the predictor by one accepted byte; return 1 when it yields a pixel byte
	function automatic bit unfilter_step(input logic [DATA_W-1:0] x, input logic st,
			output pixel_t res);
		int unsigned len, idx;
		int a, b, c, est, dist_a, dist_b, dist_c, k;
		logic [DATA_W-1:0] guess;
		len = (model_len_reg == 0) ? 1 : (model_len_reg > ROW_MAX) ? ROW_MAX : model_len_reg;
		res = '0;
		if (st) begin
			above_valid = 1'b0;
			row_pos = 0;
		end
		// type byte: latch the filter and clear the row history
		if (row_pos == 0) begin
			row_filt = (x <= DATA_W'(FILT_PAETH)) ? filter_t'(x[2:0]) : FILT_BAD;
			for (k = 0; k < BPP; k++) begin
				recent_out[k] = '0;
				recent_above[k] = '0;
			end
			row_pos = 1;
			return 1'b0;
		end
		idx = row_pos - 1;
		if (idx >= ROW_MAX) begin
			idx = ROW_MAX - 1;
		end
		a = recent_out[BPP-1];
		c = recent_above[BPP-1];
		b = above_valid ? int'(above_store[idx]) : 0;
		case (row_filt)
			FILT_SUB: guess = DATA_W'(a);
			FILT_UP: guess = DATA_W'(b);
			FILT_AVG: guess = DATA_W'((a + b) / 2);
			FILT_PAETH: begin
				// nearest neighbour to the linear estimate, ties to left then above
				est = a + b - c;
				dist_a = (est > a) ? est - a : a - est;
				dist_b = (est > b) ? est - b : b - est;
				dist_c = (est > c) ? est - c : c - est;
				if (dist_a <= dist_b && dist_a <= dist_c) begin
					guess = DATA_W'(a);
				end else if (dist_b <= dist_c) begin
					guess = DATA_W'(b);
				end else begin
					guess = DATA_W'(c);
				end
			end
			default: guess = '0;
		endcase
		res.pixel = x + guess;
		for (k = BPP - 1; k > 0; k--) begin
			recent_out[k] = recent_out[k-1];
			recent_above[k] = recent_above[k-1];
		end
		recent_out[0] = res.pixel;
		recent_above[0] = DATA_W'(b);
		above_store[idx] = res.pixel;
		above_written[idx] = 1'b1;
		res.last = (idx + 1 >= len);
		res.bad = (row_filt == FILT_BAD);
		if (res.last) begin
			row_pos = 0;
			above_valid = 1'b1;
		end else begin
			row_pos = idx + 2;
		end
		return 1'b1;
	endfunction

	// Send one byte request after a random gap and queue what it should produce
	task automatic push_byte(input logic [DATA_W-1:0] x, input logic st, input bit typed,
			input pixel_t want);
		int gap;
		int unsigned idx;
		logic start_bit;
		pixel_t got;
		bit made;
		start_bit = st;
		idx = (row_pos == 0) ? 0 : row_pos - 1;
		if (idx >= ROW_MAX) begin
			idx = ROW_MAX - 1;
		end
		// never let a data byte fetch an above byte that was never stored
		if (!start_bit && row_pos != 0 && above_valid && !above_written[idx]) begin
			start_bit = 1'b1;
		end
		gap = send_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= x;
		s_tuser <= start_bit;
		do @(posedge clk); while (s_tready !== 1'b1);
		bytes_sent++;
		made = unfilter_step(x, start_bit, got);
		if (made) begin
			pending_pixels.push_back(typed ? want : got);
		end
	endtask

	task automatic send_row(input logic [DATA_W-1:0] ftype, input logic st, input int nbytes);
		int k;
		push_byte(ftype, st, 1'b0, '0);
		for (k = 0; k < nbytes; k++) begin
			push_byte(DATA_W'($urandom), 1'b0, 1'b0, '0);
		end
	endtask

	// Drop valid, drain every expected byte, then give the pipeline time to empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_row_length(input int value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= CFG_W'(value);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		model_len_reg = CFG_W'(value);
		cfg_writes++;
	endtask

	function automatic logic [DATA_W-1:0] draw_filter();
		if ($urandom_range(0, 4) != 0) begin
			return DATA_W'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH)));
		end
		return DATA_W'($urandom_range(int'(FILT_BAD), 255));
	endfunction

	// Take result requests with random stalls and check them in order
	initial begin : result_sink
		int stall;
		pixel_t want;
		@(posedge arst_n);
		forever begin
			stall = recv_calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", m_tdata));
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata !== want.pixel) begin
					report_mismatch($sformatf("byte %0d: pixel %02h, want %02h",
						pixels_seen, m_tdata, want.pixel));
				end
				if (m_tlast !== want.last) begin
					report_mismatch($sformatf("byte %0d: last %b, want %b",
						pixels_seen, m_tlast, want.last));
				end
				if (m_tuser !== want.bad) begin
					report_mismatch($sformatf("byte %0d: bad_filter %b, want %b",
						pixels_seen, m_tuser, want.bad));
				end
			end
		end
	end

	initial begin : stimulus
		int fixed_lengths [] = '{0, 1, 2, 3, 5, 7, 8, 9, 16, 33, 100, 4};
		int phase, len, eff, rows, r, nbytes, random_base;
		bit force_start;
		// hold reset from the start
		arst_n = 1'b0;
		// predictor reset
		model_len_reg = ROW_LENGTH_RST;
		foreach (above_store[i]) begin
			above_store[i] = '0;
			above_written[i] = 1'b0;
		end
		foreach (recent_out[i]) begin
			recent_out[i] = '0;
			recent_above[i] = '0;
		end
		row_pos = 0;
		row_filt = FILT_NONE;
		above_valid = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening at the reset length
		foreach (opening[i]) begin
			push_byte(opening[i].data, opening[i].start, opening[i].typed, opening[i].want);
		end
		// shorten the length mid-row: the next byte is past it and closes the row
		write_row_length(1);
		push_byte(8'h40, 1'b0, 1'b0, '0);

		// top length value: a long row must stay open, and the next length or a restart closes it
		write_row_length(CFG_MAX);
		send_calm = 1'b1;
		recv_calm = 1'b1;
		send_row(DATA_W'(FILT_PAETH), 1'b1, LONG_PART);

		// random phases at mostly short lengths
		random_base = bytes_sent;
		for (phase = 0; bytes_sent - random_base < RANDOM_BYTES; phase++) begin
			if (phase < fixed_lengths.size()) begin
				len = fixed_lengths[phase];
			end else begin
				case ($urandom_range(0, 9))
					0: len = 0;
					1: len = $urandom_range(41, 300);
					default: len = $urandom_range(1, 40);
				endcase
			end
			write_row_length(len);
			send_calm = ($urandom_range(0, 3) == 0);
			recv_calm = ($urandom_range(0, 3) == 0);
			eff = (len == 0) ? 1 : (len > ROW_MAX) ? ROW_MAX : len;
			rows = $urandom_range(1, (eff < 60) ? 60 / (eff + 1) + 1 : 1);
			force_start = ($urandom_range(0, 1) == 1);
			for (r = 0; r < rows; r++) begin
				nbytes = eff;
				// now and then break a row off and restart the image
				if ($urandom_range(0, 14) == 0) begin
					nbytes = $urandom_range(0, eff - 1);
				end
				send_row(draw_filter(), force_start || ($urandom_range(0, 9) == 0), nbytes);
				force_start = (nbytes != eff);
			end
			// sometimes leave a row open so the next length lands on it
			if ($urandom_range(0, 5) == 0) begin
				send_row(draw_filter(), 1'b0, $urandom_range(0, eff - 1));
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d expected bytes never arrived", pending_pixels.size()));
		end
		$display("Sent %0d stream bytes, checked %0d pixel bytes, %0d row length writes.",
			bytes_sent, pixels_seen, cfg_writes);
		$display("Covered all five filters, unknown types, image restarts, broken rows,");
		$display("zero and top-value lengths and a length change inside a row.");
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
